// ===== sv/cbsa_pkg.sv =====
package cbsa_pkg;

   // Field and datapath widths
   localparam int OFF_W      = 24;
   localparam int ADDR_W     = 32;
   localparam int CORD_W     = 16;
   localparam int BYTE_W     = 8;
   localparam int DIMS_W     = 2;
   localparam int DIV_W      = 3 * CORD_W;
   localparam int BND_W      = DIV_W + BYTE_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_X    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_Y    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_Z    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRAY_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRAY_Z    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEM_BYTES = 3'd6;

   // Dimension counts
   localparam logic [DIMS_W-1:0] DIMS_1D = 2'd1;
   localparam logic [DIMS_W-1:0] DIMS_2D = 2'd2;
   localparam logic [DIMS_W-1:0] DIMS_3D = 2'd3;

   // Word state that travels down the pipeline beside the datapath
   typedef struct packed {
      logic              valid;
      logic              empty;
      logic [CORD_W-1:0] start_x;
      logic [CORD_W-1:0] start_y;
      logic [CORD_W-1:0] start_z;
      logic [BYTE_W-1:0] value;
      logic [OFF_W-1:0]  plane;
      logic [OFF_W-1:0]  rem_z;
   } cbsa_tag_type;

   // Settings seen by the address stages
   typedef struct packed {
      logic [DIMS_W-1:0] nd;
      logic [CORD_W-1:0] array_z;
      logic [BYTE_W-1:0] elem_bytes;
      logic [ADDR_W-1:0] stride_x;
      logic [BND_W-1:0]  bound;
   } cbsa_cfg_type;

endpackage

// ===== sv/cbsa_div.sv =====
module cbsa_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [cbsa_pkg::OFF_W-1:0]   dividend,
   input  logic [cbsa_pkg::DIV_W-1:0]   divisor,
   input  cbsa_pkg::cbsa_tag_type       tag_in,
   output logic [cbsa_pkg::OFF_W-1:0]   quotient,
   output logic [cbsa_pkg::OFF_W-1:0]   remainder,
   output cbsa_pkg::cbsa_tag_type       tag_out
);
   import cbsa_pkg::*;

   logic [OFF_W-1:0] rem_st [0:OFF_W];
   logic [OFF_W-1:0] quo_st [0:OFF_W];
   cbsa_tag_type     tag_st [0:OFF_W];

   // Restoring division, one quotient bit per stage
   assign rem_st[0] = '0;
   assign quo_st[0] = dividend;
   assign tag_st[0] = tag_in;

   for (genvar i = 0; i < OFF_W; i++) begin : g_step
      logic [OFF_W:0]   trial;
      logic [DIV_W-1:0] trial_ext;
      logic [DIV_W-1:0] diff;
      logic             take;
      logic [OFF_W-1:0] rem_in;
      logic [OFF_W-1:0] quo_in;
      logic [OFF_W-1:0] rem_ff;
      logic [OFF_W-1:0] quo_ff;
      cbsa_tag_type     tag_ff;

      always_comb begin
         trial     = {rem_st[i], quo_st[i][OFF_W-1]};
         trial_ext = {{(DIV_W-OFF_W-1){1'b0}}, trial};
         diff      = trial_ext - divisor;
         take      = trial_ext >= divisor;
         rem_in    = take ? diff[OFF_W-1:0] : trial[OFF_W-1:0];
         quo_in    = {quo_st[i][OFF_W-2:0], take};
      end

      // Advance the stage, clear its valid bit on reset
      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff.valid <= 1'b0;
         end else if (advance) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            tag_ff <= tag_st[i];
         end
      end

      assign rem_st[i+1] = rem_ff;
      assign quo_st[i+1] = quo_ff;
      assign tag_st[i+1] = tag_ff;
   end

   assign quotient  = quo_st[OFF_W];
   assign remainder = rem_st[OFF_W];
   assign tag_out   = tag_st[OFF_W];

endmodule

// ===== sv/cbsa_addr.sv =====
module cbsa_addr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  cbsa_pkg::cbsa_cfg_type        cfg,
   input  cbsa_pkg::cbsa_tag_type        tag,
   input  logic [cbsa_pkg::OFF_W-1:0]    quo_x,
   input  logic [cbsa_pkg::OFF_W-1:0]    rem_y,
   output logic                          rsp_valid,
   output logic                          rsp_write_ok,
   output logic [cbsa_pkg::ADDR_W-1:0]   rsp_dest_address,
   output logic [cbsa_pkg::BYTE_W-1:0]   rsp_out_value
);
   import cbsa_pkg::*;

   logic [OFF_W:0]    x1_in, x1_ff;
   logic [CORD_W:0]   y1_in, y1_ff;
   logic [CORD_W:0]   z1_in, z1_ff;
   cbsa_tag_type      t1_ff, t2_ff, t3_ff, t4_ff;
   logic [ADDR_W-1:0] px_in, px_ff;
   logic [ADDR_W-1:0] py_in, py_ff;
   logic [ADDR_W-1:0] pz_in, pz_ff;
   logic [ADDR_W-1:0] el_in, el_ff;
   logic [ADDR_W-1:0] ad_in, ad_ff;
   logic [ADDR_W-1:0] scaled;
   logic              ok_in;
   logic              rsp_valid_ff;
   logic              rsp_write_ok_ff;
   logic [ADDR_W-1:0] rsp_dest_address_ff;
   logic [BYTE_W-1:0] rsp_out_value_ff;

   // Shift chunk coordinates by the start
   always_comb begin
      x1_in = {1'b0, quo_x} + {{(OFF_W-CORD_W+1){1'b0}}, tag.start_x};
      if (cfg.nd == DIMS_3D) begin
         y1_in = {1'b0, rem_y[CORD_W-1:0]} + {1'b0, tag.start_y};
      end else begin
         y1_in = {1'b0, tag.rem_z[CORD_W-1:0]} + {1'b0, tag.start_y};
      end
      z1_in = {1'b0, tag.rem_z[CORD_W-1:0]} + {1'b0, tag.start_z};
   end

   // Scale each coordinate by its row-major stride
   always_comb begin
      px_in = ADDR_W'({{(ADDR_W-OFF_W-1){1'b0}}, x1_ff} * cfg.stride_x);
      pz_in = '0;
      case (cfg.nd)
         DIMS_3D: begin
            py_in = {{(ADDR_W-CORD_W-1){1'b0}}, y1_ff} *
                    {{(ADDR_W-CORD_W){1'b0}}, cfg.array_z};
            pz_in = {{(ADDR_W-CORD_W-1){1'b0}}, z1_ff};
         end
         DIMS_2D: begin
            py_in = {{(ADDR_W-CORD_W-1){1'b0}}, y1_ff};
         end
         default: begin
            py_in = '0;
         end
      endcase
   end

   // Sum the element index, then scale by element size and add the plane
   assign el_in  = px_ff + py_ff + pz_ff;
   assign scaled = el_ff * {{(ADDR_W-BYTE_W){1'b0}}, cfg.elem_bytes};
   assign ad_in  = scaled + {{(ADDR_W-OFF_W){1'b0}}, t3_ff.plane};
   assign ok_in  = !t4_ff.empty && ({{(BND_W-ADDR_W){1'b0}}, ad_ff} < cfg.bound);

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff.valid  <= 1'b0;
         t2_ff.valid  <= 1'b0;
         t3_ff.valid  <= 1'b0;
         t4_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         x1_ff               <= x1_in;
         y1_ff               <= y1_in;
         z1_ff               <= z1_in;
         t1_ff               <= tag;
         px_ff               <= px_in;
         py_ff               <= py_in;
         pz_ff               <= pz_in;
         t2_ff               <= t1_ff;
         el_ff               <= el_in;
         t3_ff               <= t2_ff;
         ad_ff               <= ad_in;
         t4_ff               <= t3_ff;
         rsp_valid_ff        <= t4_ff.valid;
         rsp_write_ok_ff     <= ok_in;
         rsp_dest_address_ff <= t4_ff.empty ? '0 : ad_ff;
         rsp_out_value_ff    <= t4_ff.value;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_ok     = rsp_write_ok_ff;
   assign rsp_dest_address = rsp_dest_address_ff;
   assign rsp_out_value    = rsp_out_value_ff;

endmodule

// ===== sv/chunk_byte_scatter_address.sv =====
// Throughput: one word per cycle unless a result is held; three 24-stage restoring
// dividers, one quotient bit per stage, and five address stages all advance together.
// A stalled result freezes the whole pipeline; an empty output never blocks input.
// Reset (synchronous) clears every valid bit and sets all configuration registers to 1;
// the derived element count, bound and x stride are registered from them.
module chunk_byte_scatter_address (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [cbsa_pkg::OFF_W-1:0]            req_byte_offset,
   input  logic [cbsa_pkg::CORD_W-1:0]           req_start_x,
   input  logic [cbsa_pkg::CORD_W-1:0]           req_start_y,
   input  logic [cbsa_pkg::CORD_W-1:0]           req_start_z,
   input  logic [cbsa_pkg::BYTE_W-1:0]           req_byte_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_write_ok,
   output logic [cbsa_pkg::ADDR_W-1:0]           rsp_dest_address,
   output logic [cbsa_pkg::BYTE_W-1:0]           rsp_out_value,
   input  logic                                  csr_write,
   input  logic [cbsa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cbsa_pkg::CSR_DATA_W-1:0]       csr_data
);
   import cbsa_pkg::*;

   logic [DIMS_W-1:0] dims_ff;
   logic [CORD_W-1:0] chunk_x_ff, chunk_y_ff, chunk_z_ff;
   logic [CORD_W-1:0] array_y_ff, array_z_ff;
   logic [BYTE_W-1:0] elem_bytes_ff;
   logic [DIMS_W-1:0] nd;
   logic [CORD_W-1:0] cy_used, cz_used;
   logic [2*CORD_W-1:0] cxy_ff;
   logic [DIV_W-1:0]  elems_ff;
   logic [BND_W-1:0]  bound_ff;
   logic [ADDR_W-1:0] stride_x_in, stride_x_ff;
   logic              advance;
   cbsa_tag_type      p0_in, p0_ff, p1_ff;
   logic [OFF_W-1:0]  off0_ff, off1_ff;
   cbsa_tag_type      tag_a_in, tag_a, tag_b_in, tag_b, tag_c_in, tag_c;
   logic [OFF_W-1:0]  quo_a, rem_a, quo_b, rem_b, quo_c, rem_c;
   logic [DIV_W-1:0]  div_b, div_c;
   cbsa_cfg_type      acfg;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff       <= DIMS_1D;
         chunk_x_ff    <= CORD_W'(1);
         chunk_y_ff    <= CORD_W'(1);
         chunk_z_ff    <= CORD_W'(1);
         array_y_ff    <= CORD_W'(1);
         array_z_ff    <= CORD_W'(1);
         elem_bytes_ff <= BYTE_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            CSR_DIMS:       dims_ff       <= csr_data[DIMS_W-1:0];
            CSR_CHUNK_X:    chunk_x_ff    <= csr_data[CORD_W-1:0];
            CSR_CHUNK_Y:    chunk_y_ff    <= csr_data[CORD_W-1:0];
            CSR_CHUNK_Z:    chunk_z_ff    <= csr_data[CORD_W-1:0];
            CSR_ARRAY_Y:    array_y_ff    <= csr_data[CORD_W-1:0];
            CSR_ARRAY_Z:    array_z_ff    <= csr_data[CORD_W-1:0];
            CSR_ELEM_BYTES: elem_bytes_ff <= csr_data[BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Dimension count, zero counts as one
   assign nd      = (dims_ff == '0) ? DIMS_1D : dims_ff;
   assign cy_used = (nd == DIMS_1D) ? CORD_W'(1) : chunk_y_ff;
   assign cz_used = (nd == DIMS_3D) ? chunk_z_ff : CORD_W'(1);

   always_comb begin
      case (nd)
         DIMS_3D: stride_x_in = {{(ADDR_W-CORD_W){1'b0}}, array_y_ff} *
                                {{(ADDR_W-CORD_W){1'b0}}, array_z_ff};
         DIMS_2D: stride_x_in = {{(ADDR_W-CORD_W){1'b0}}, array_y_ff};
         default: stride_x_in = ADDR_W'(1);
      endcase
   end

   // Derive element count and bound through cxy_ff, elems_ff and bound_ff, and x stride in stride_x_ff
   always_ff @(posedge clock) begin
      cxy_ff      <= {{CORD_W{1'b0}}, chunk_x_ff} * {{CORD_W{1'b0}}, cy_used};
      elems_ff    <= {{CORD_W{1'b0}}, cxy_ff} * {{(2*CORD_W){1'b0}}, cz_used};
      bound_ff    <= {{BYTE_W{1'b0}}, elems_ff} * {{DIV_W{1'b0}}, elem_bytes_ff};
      stride_x_ff <= stride_x_in;
   end

   // Whole pipeline moves unless a result is held
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      p0_in         = '0;
      p0_in.valid   = req_valid;
      p0_in.start_x = req_start_x;
      p0_in.start_y = req_start_y;
      p0_in.start_z = req_start_z;
      p0_in.value   = req_byte_value;
   end

   // Two entry stages give the derived settings time to settle
   always_ff @(posedge clock) begin
      if (reset) begin
         p0_ff.valid <= 1'b0;
         p1_ff.valid <= 1'b0;
      end else if (advance) begin
         p0_ff   <= p0_in;
         off0_ff <= req_byte_offset;
         p1_ff   <= p0_ff;
         off1_ff <= off0_ff;
      end
   end

   always_comb begin
      tag_a_in       = p1_ff;
      tag_a_in.empty = (elems_ff == '0);
      tag_b_in       = tag_a;
      tag_b_in.plane = quo_a;
      tag_c_in       = tag_b;
      tag_c_in.rem_z = rem_b;
   end

   assign div_b = {{(DIV_W-CORD_W){1'b0}},
                   (nd == DIMS_3D) ? chunk_z_ff : cy_used};
   assign div_c = {{(DIV_W-CORD_W){1'b0}},
                   (nd == DIMS_3D) ? chunk_y_ff : CORD_W'(1)};

   // Offset into plane and element index
   cbsa_div u_div_a (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .dividend  (off1_ff),
      .divisor   (elems_ff),
      .tag_in    (tag_a_in),
      .quotient  (quo_a),
      .remainder (rem_a),
      .tag_out   (tag_a)
   );

   // Element index into innermost coordinate and rest
   cbsa_div u_div_b (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .dividend  (rem_a),
      .divisor   (div_b),
      .tag_in    (tag_b_in),
      .quotient  (quo_b),
      .remainder (rem_b),
      .tag_out   (tag_b)
   );

   // Rest into outer and middle coordinates
   cbsa_div u_div_c (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .dividend  (quo_b),
      .divisor   (div_c),
      .tag_in    (tag_c_in),
      .quotient  (quo_c),
      .remainder (rem_c),
      .tag_out   (tag_c)
   );

   always_comb begin
      acfg            = '0;
      acfg.nd         = nd;
      acfg.array_z    = array_z_ff;
      acfg.elem_bytes = elem_bytes_ff;
      acfg.stride_x   = stride_x_ff;
      acfg.bound      = bound_ff;
   end

   cbsa_addr u_addr (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .cfg              (acfg),
      .tag              (tag_c),
      .quo_x            (quo_c),
      .rem_y            (rem_c),
      .rsp_valid        (rsp_valid),
      .rsp_write_ok     (rsp_write_ok),
      .rsp_dest_address (rsp_dest_address),
      .rsp_out_value    (rsp_out_value)
   );

endmodule

// ===== sv/cbsa_check.sv =====
module cbsa_check (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_write_ok,
   input logic [cbsa_pkg::ADDR_W-1:0]           rsp_dest_address,
   input logic [cbsa_pkg::BYTE_W-1:0]           rsp_out_value
);
   import cbsa_pkg::*;

   // Nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

   // A held result freezes the input side
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result held");

   // An empty output never blocks input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   // A held result word keeps its contents
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dest_address)
         && $stable(rsp_write_ok) && $stable(rsp_out_value))
      else $error("held result word changed");

endmodule

bind chunk_byte_scatter_address cbsa_check u_cbsa_check (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_write_ok     (rsp_write_ok),
   .rsp_dest_address (rsp_dest_address),
   .rsp_out_value    (rsp_out_value)
);
